// File: rtl/core/svt_pkg.sv
// types and constants shared by the sorted value table cells and top level
// no dependencies
`default_nettype none

package svt_pkg;

    typedef logic signed [31:0] key_t;

    typedef logic [1:0] req_code_t;

    localparam req_code_t REQ_INSERT = 2'd0;
    localparam req_code_t REQ_SEARCH = 2'd1;
    localparam req_code_t REQ_REMOVE = 2'd2;

    // shift commands broadcast to every cell in the apply cycle
    typedef struct packed {
        logic ins;
        logic rem;
    } svt_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/svt_cell.sv
// one slot of the sorted chain: stored entry plus compare flags
// depends on svt_pkg
`default_nettype none

module svt_cell (
    input  logic             clk,
    input  logic             sample,
    input  svt_pkg::key_t    value,
    input  logic             occ,
    input  logic             tail,
    input  svt_pkg::svt_cmd_t cmd,
    input  svt_pkg::key_t    key,
    input  logic             left_gt,
    input  svt_pkg::key_t    left_entry,
    input  svt_pkg::key_t    right_entry,
    output svt_pkg::key_t    entry,
    output logic             gt,
    output logic             eq
);
    import svt_pkg::*;

    key_t entry_reg;
    key_t entry_next;
    logic gt_reg;
    logic eq_reg;

    always_comb
    begin
        priority if (cmd.ins)
        begin
            // larger entries move up one slot, the new key lands at the boundary
            if (left_gt)
                entry_next = left_entry;
            else if (gt_reg || tail)
                entry_next = key;
            else
                entry_next = entry_reg;
        end
        else if (cmd.rem && (gt_reg || eq_reg))
        begin
            // first match and everything above it move down one slot
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            gt_reg <= occ && (entry_reg > value);
            eq_reg <= occ && (entry_reg == value);
        end
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

// File: rtl/core/sorted_value_table.sv
// sorted value table: ascending chain of compare-and-shift cells
// an item is taken at the edge with start high and busy low; busy is high for
// one cycle after that, and done pulses in the cycle after, so a new item can
// be taken in the cycle that done is high. the cells register their compare
// flags at the accept edge and shift at the end of the apply cycle.
// reset clears the count and control; cell contents are unwritten until used
`default_nettype none

module sorted_value_table #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  svt_pkg::req_code_t  req_type,
    input  svt_pkg::key_t       value,
    output logic                done,
    output logic                hit,
    output logic                rejected,
    output logic [4:0]          entry_count
);
    import svt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    req_code_t        op_reg;
    key_t             key_reg;
    logic             done_reg;
    logic             hit_reg;
    logic             hit_next;
    logic             rej_reg;
    logic             rej_next;

    logic             accept;
    logic             found;
    logic             full;
    svt_cmd_t         cmd;

    key_t             entry_vec [DEPTH];
    logic [DEPTH-1:0] gt_vec;
    logic [DEPTH-1:0] eq_vec;
    logic [CNT_W+4:0] count_ext;

    assign accept = start && !busy;
    assign found  = |eq_vec;
    assign full   = (count_reg == FULL_CNT);

    always_comb
    begin
        cmd.ins    = 1'b0;
        cmd.rem    = 1'b0;
        hit_next   = 1'b0;
        rej_next   = 1'b0;
        count_next = count_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
                if (op_reg == REQ_INSERT)
                begin
                    if (full)
                        rej_next = 1'b1;
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (op_reg == REQ_SEARCH)
                begin
                    hit_next = found;
                end
                else if (op_reg == REQ_REMOVE)
                begin
                    hit_next = found;
                    if (found)
                    begin
                        cmd.rem    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic left_gt;
            key_t left_entry;
            key_t right_entry;

            if (i == 0)
            begin : g_first
                assign left_gt    = 1'b0;
                assign left_entry = entry_vec[0];
            end
            else
            begin : g_mid
                assign left_gt    = gt_vec[i-1];
                assign left_entry = entry_vec[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_entry = entry_vec[i];
            end
            else
            begin : g_inner
                assign right_entry = entry_vec[i+1];
            end

            svt_cell u_cell (
                .clk         (clk),
                .sample      (accept),
                .value       (value),
                .occ         (CNT_W'(i) < count_reg),
                .tail        (CNT_W'(i) == count_reg),
                .cmd         (cmd),
                .key         (key_reg),
                .left_gt     (left_gt),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entry_vec[i]),
                .gt          (gt_vec[i]),
                .eq          (eq_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req_type;
            key_reg <= value;
        end
        if (state_reg == ST_APPLY)
        begin
            hit_reg <= hit_next;
            rej_reg <= rej_next;
        end
    end

    assign count_ext   = {5'b0, count_reg};
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign hit         = hit_reg;
    assign rejected    = rej_reg;
    assign entry_count = count_ext[4:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above table depth");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted item did not enter the apply cycle");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("apply cycle did not produce a result");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && rejected |-> !hit && $stable(count_reg) && full)
        else $error("rejected insert with table not full");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> $stable(count_reg))
        else $error("count changed outside the apply cycle");

endmodule

`default_nettype wire

// File: dv/tb_sorted_value_table.sv
// testbench for sorted_value_table: a directed opening, then random requests
// checked against a shadow copy of the sorted list kept in a small class
// depends on svt_pkg and the sorted_value_table rtl
`timescale 1ns / 100ps

module tb_sorted_value_table;
    import svt_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam req_code_t REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic       hit;
        logic       rejected;
        logic [4:0] count;
    } answer_t;

    // shadow of the sorted list plus the answers still owed by the block
    class sorted_table_tracker;
        int          depth;
        key_t        shadow_list[$];
        answer_t     due_answers[$];
        int unsigned errors;
        int unsigned n_insert, n_refused, n_search, n_found, n_remove, n_deleted, n_unused;

        function new(int d);
            depth = d;
        endfunction

        function void note_request(req_code_t op, key_t v);
            answer_t a;
            int      pos;
            a = '0;
            pos = 0;
            case (op)
                REQ_INSERT:
                begin
                    n_insert++;
                    if (shadow_list.size() >= depth)
                    begin
                        a.rejected = 1'b1;
                        n_refused++;
                    end
                    else
                    begin
                        while (pos < shadow_list.size() && shadow_list[pos] <= v)
                            pos++;
                        shadow_list.insert(pos, v);
                    end
                end
                REQ_SEARCH:
                begin
                    n_search++;
                    foreach (shadow_list[i])
                        if (shadow_list[i] == v)
                            a.hit = 1'b1;
                    if (a.hit)
                        n_found++;
                end
                REQ_REMOVE:
                begin
                    n_remove++;
                    while (pos < shadow_list.size() && shadow_list[pos] != v)
                        pos++;
                    // only one of several equal entries goes
                    if (pos < shadow_list.size())
                    begin
                        shadow_list.delete(pos);
                        a.hit = 1'b1;
                        n_deleted++;
                    end
                end
                default:
                    n_unused++;
            endcase
            a.count = 5'(shadow_list.size());
            due_answers.push_back(a);
        endfunction

        function void check_answer(logic hit, logic rejected, logic [4:0] count);
            answer_t want;
            if (due_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: hit=%0b rejected=%0b entry_count=%0d",
                         $time, hit, rejected, count);
                return;
            end
            want = due_answers.pop_front();
            if (hit !== want.hit)
            begin
                errors++;
                $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
            end
            if (rejected !== want.rejected)
            begin
                errors++;
                $display("%0t: rejected expected %0b actual %0b", $time, want.rejected,
                         rejected);
            end
            if (count !== want.count)
            begin
                errors++;
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                         count);
            end
        endfunction

        function key_t pick_stored();
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_code_t  req_type;
    key_t       value;
    logic       done;
    logic       hit;
    logic       rejected;
    logic [4:0] entry_count;

    sorted_table_tracker tracker;
    int unsigned         idle_cycles;
    int unsigned         accepted_items;

    sorted_value_table #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .value(value),
        .done(done),
        .hit(hit),
        .rejected(rejected),
        .entry_count(entry_count)
    );

    always #5 clk = ~clk;

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                tracker.note_request(req_type, value);
                accepted_items++;
            end
            if (done)
                tracker.check_answer(hit, rejected, entry_count);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL sorted_value_table");
                $finish;
            end
        end
    end

    task automatic drive_request(req_code_t op, key_t v);
        start <= 1'b1;
        req_type <= op;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic idle_gap(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // mostly stored values and a few hot values, so searches and removes hit
    function automatic key_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && tracker.shadow_list.size() > 0)
            return tracker.pick_stored();
        if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                default: return key_t'(int'($urandom_range(0, 8)) - 4);
            endcase
        end
        return key_t'($urandom);
    endfunction

    // swings between filling and draining so full and empty both come up often
    task automatic run_random(int n, int pct);
        bit        filling;
        int        r;
        int        ins_top;
        int        srch_top;
        req_code_t op;
        filling = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (tracker.shadow_list.size() >= DEPTH)
                filling = 1'b0;
            else if (tracker.shadow_list.size() == 0)
                filling = 1'b1;
            ins_top = filling ? 63 : 23;
            srch_top = filling ? 80 : 43;
            r = $urandom_range(0, 99);
            if (r < 3)
                op = REQ_UNUSED;
            else if (r < ins_top)
                op = REQ_INSERT;
            else if (r < srch_top)
                op = REQ_SEARCH;
            else
                op = REQ_REMOVE;
            drive_request(op, pick_value());
            idle_gap(pct);
        end
    endtask

    initial
    begin
        tracker = new(DEPTH);
        idle_cycles = 0;
        accepted_items = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_INSERT;
        value = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table
        drive_request(REQ_SEARCH, 32'sd5);
        drive_request(REQ_REMOVE, 32'sd5);
        drive_request(REQ_UNUSED, 32'sd5);
        // extremes and a duplicate
        drive_request(REQ_INSERT, 32'sh8000_0000);
        drive_request(REQ_INSERT, 32'sh7fff_ffff);
        drive_request(REQ_INSERT, 32'sd0);
        drive_request(REQ_INSERT, 32'sd0);
        drive_request(REQ_SEARCH, 32'sh7fff_ffff);
        drive_request(REQ_SEARCH, 32'sd1);
        drive_request(REQ_REMOVE, 32'sd0);
        drive_request(REQ_REMOVE, -32'sd5);
        drive_request(REQ_UNUSED, 32'shffff_ffff);
        // fill up, then push against the full table
        while (tracker.shadow_list.size() < DEPTH)
            drive_request(REQ_INSERT, key_t'($urandom));
        drive_request(REQ_INSERT, 32'sd0);
        drive_request(REQ_REMOVE, 32'sh7fff_ffff);

        run_random(325, 0);
        run_random(325, 83);
        run_random(325, 0);
        run_random(325, 27);
        start <= 1'b0;

        while (tracker.due_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d requests: %0d inserts (%0d refused full), %0d searches (%0d found)",
                 accepted_items, tracker.n_insert, tracker.n_refused, tracker.n_search,
                 tracker.n_found);
        $display("  %0d removes (%0d deleted), %0d unused codes, %0d mismatches",
                 tracker.n_remove, tracker.n_deleted, tracker.n_unused, tracker.errors);
        if (tracker.errors == 0)
            $display("PASS sorted_value_table");
        else
            $display("FAIL sorted_value_table");
        $finish;
    end

endmodule
